// ===== design/ntl_pkg.sv =====
package ntl_pkg;

  localparam int LINE_BITS_DEF = 32;
  localparam int START_BITS    = 32;
  localparam int RUN_MAX       = 3;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3b;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_QUOTE,
    MODE_COMMENT
  } lex_mode_t;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_END   = 2'd1,
    EV_ERROR = 2'd2
  } ev_t;

  typedef enum logic [1:0] {
    TYPE_WORD  = 2'd0,
    TYPE_PUNCT = 2'd1,
    TYPE_QUOTE = 2'd2
  } tok_t;

  typedef struct packed {
    ev_t                   event_res;
    logic [7:0]            content;
    tok_t                  token_type;
    logic [START_BITS-1:0] start_line;
    logic                  last_of_run;
  } res_t;

endpackage

// ===== design/ntl_in_if.sv =====
interface ntl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source(output valid, output kind, output text_byte, input ready);
  modport sink(input valid, input kind, input text_byte, output ready);
endinterface

// ===== design/ntl_out_if.sv =====
interface ntl_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    event_res;
  logic [7:0]                    content;
  logic [1:0]                    token_type;
  logic [ntl_pkg::START_BITS-1:0] start_line;
  logic                          last_of_run;

  modport source(output valid, output event_res, output content, output token_type,
                 output start_line, output last_of_run, input ready);
  modport sink(input valid, input event_res, input content, input token_type,
               input start_line, input last_of_run, output ready);
endinterface

// ===== design/netlist_text_lexer_core.sv =====
// Byte-serial tokenizer for netlist text. One beat on text carries a byte or an
// end-of-input mark; each beat yields zero to three result beats on tokens (content
// bytes, token ends, unterminated-quote error), the final one flagged last_of_run.
// Bytes are taken one per cycle while tokens keeps up: a byte goes through an
// input register and a single pass of decode logic into a three-entry result
// buffer, which drains one beat per cycle. A byte giving one result sustains one
// byte per cycle; a byte giving more results holds the input side while the buffer
// drains. One byte can wait in the input register while the buffer is stalled.
// The line counter is LINE_BITS wide and saturates; start_line clips it to 32 bits.
module netlist_text_lexer_core #(
  parameter int LINE_BITS = ntl_pkg::LINE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ntl_in_if.sink    text,
  ntl_out_if.source tokens
);

  // input register
  logic       s1_valid;
  logic       s1_kind;
  logic [7:0] s1_byte;

  // lexer state
  ntl_pkg::lex_mode_t   mode, mode_next;
  logic                 esc, esc_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic [LINE_BITS-1:0] tsl, tsl_next;

  // result buffer
  ntl_pkg::res_t res [ntl_pkg::RUN_MAX];
  ntl_pkg::res_t res_next [ntl_pkg::RUN_MAX];
  logic [1:0]    cnt, cnt_next;
  logic [1:0]    idx;

  logic adv, take, take_last;
  logic [LINE_BITS-1:0]           line_inc;
  logic [ntl_pkg::START_BITS-1:0] start_cur, start_new;
  logic is_sp, is_pu, is_hash, is_q, is_bs, is_lf;

  generate
    if (LINE_BITS > ntl_pkg::START_BITS) begin : g_clip
      assign start_cur = (|tsl[LINE_BITS-1:ntl_pkg::START_BITS]) ? '1
                         : tsl[ntl_pkg::START_BITS-1:0];
      assign start_new = (|line[LINE_BITS-1:ntl_pkg::START_BITS]) ? '1
                         : line[ntl_pkg::START_BITS-1:0];
    end else if (LINE_BITS == ntl_pkg::START_BITS) begin : g_same
      assign start_cur = tsl;
      assign start_new = line;
    end else begin : g_ext
      assign start_cur = {{(ntl_pkg::START_BITS-LINE_BITS){1'b0}}, tsl};
      assign start_new = {{(ntl_pkg::START_BITS-LINE_BITS){1'b0}}, line};
    end
  endgenerate

  assign line_inc = (line != '1) ? line + LINE_BITS'(1) : line;

  assign is_lf   = (s1_byte == ntl_pkg::CH_LF);
  assign is_sp   = (s1_byte == ntl_pkg::CH_SPACE) || (s1_byte == ntl_pkg::CH_TAB) ||
                   (s1_byte == ntl_pkg::CH_CR) || is_lf || (s1_byte == ntl_pkg::CH_FF);
  assign is_pu   = (s1_byte == ntl_pkg::CH_LPAREN) || (s1_byte == ntl_pkg::CH_RPAREN) ||
                   (s1_byte == ntl_pkg::CH_SEMI);
  assign is_hash = (s1_byte == ntl_pkg::CH_HASH);
  assign is_q    = (s1_byte == ntl_pkg::CH_QUOTE);
  assign is_bs   = (s1_byte == ntl_pkg::CH_BSLASH);

  assign tokens.valid       = (cnt != 2'd0);
  assign tokens.event_res   = res[idx].event_res;
  assign tokens.content     = res[idx].content;
  assign tokens.token_type  = res[idx].token_type;
  assign tokens.start_line  = res[idx].start_line;
  assign tokens.last_of_run = res[idx].last_of_run;

  assign take      = tokens.valid && tokens.ready;
  assign take_last = take && res[idx].last_of_run;
  assign adv       = s1_valid && ((cnt == 2'd0) || take_last);
  assign text.ready = !s1_valid || adv;

  // one pass of decode for the byte in the input register
  always_comb begin
    logic       do_idle;
    logic [1:0] k;
    mode_next = mode;
    esc_next  = esc;
    line_next = line;
    tsl_next  = tsl;
    do_idle   = 1'b0;
    k         = 2'd0;
    for (int i = 0; i < ntl_pkg::RUN_MAX; i++) begin
      res_next[i] = '{ntl_pkg::EV_BYTE, 8'd0, ntl_pkg::TYPE_WORD, start_cur, 1'b0};
    end
    if (s1_kind) begin
      if (mode == ntl_pkg::MODE_WORD) begin
        res_next[k] = '{ntl_pkg::EV_END, 8'd0, ntl_pkg::TYPE_WORD, start_cur, 1'b0};
        k = k + 2'd1;
      end else if (mode == ntl_pkg::MODE_QUOTE) begin
        res_next[k] = '{ntl_pkg::EV_ERROR, 8'd0, ntl_pkg::TYPE_QUOTE, start_cur, 1'b0};
        k = k + 2'd1;
      end
      mode_next = ntl_pkg::MODE_IDLE;
      esc_next  = 1'b0;
    end else begin
      case (mode)
        ntl_pkg::MODE_IDLE: begin
          do_idle = 1'b1;
        end
        ntl_pkg::MODE_COMMENT: begin
          if (is_lf) begin
            line_next = line_inc;
            mode_next = ntl_pkg::MODE_IDLE;
          end
        end
        ntl_pkg::MODE_WORD: begin
          if (is_sp || is_pu || is_hash) begin
            res_next[k] = '{ntl_pkg::EV_END, 8'd0, ntl_pkg::TYPE_WORD, start_cur, 1'b0};
            k = k + 2'd1;
            mode_next = ntl_pkg::MODE_IDLE;
            do_idle   = 1'b1;
          end else begin
            res_next[k] = '{ntl_pkg::EV_BYTE, s1_byte, ntl_pkg::TYPE_WORD, start_cur, 1'b0};
            k = k + 2'd1;
          end
        end
        ntl_pkg::MODE_QUOTE: begin
          if (is_lf) line_next = line_inc;
          if (is_q && !esc) begin
            res_next[k] = '{ntl_pkg::EV_END, 8'd0, ntl_pkg::TYPE_QUOTE, start_cur, 1'b0};
            k = k + 2'd1;
            mode_next = ntl_pkg::MODE_IDLE;
            esc_next  = 1'b0;
          end else begin
            res_next[k] = '{ntl_pkg::EV_BYTE, s1_byte, ntl_pkg::TYPE_QUOTE, start_cur, 1'b0};
            k = k + 2'd1;
            esc_next = is_bs && !esc;
          end
        end
        default: begin
          mode_next = ntl_pkg::MODE_IDLE;
        end
      endcase
      // byte seen between tokens, also the byte that just closed a word
      if (do_idle) begin
        if (is_hash) begin
          mode_next = ntl_pkg::MODE_COMMENT;
        end else if (is_sp) begin
          if (is_lf) line_next = line_inc;
        end else if (is_pu) begin
          tsl_next = line;
          res_next[k] = '{ntl_pkg::EV_BYTE, s1_byte, ntl_pkg::TYPE_PUNCT, start_new, 1'b0};
          k = k + 2'd1;
          res_next[k] = '{ntl_pkg::EV_END, 8'd0, ntl_pkg::TYPE_PUNCT, start_new, 1'b0};
          k = k + 2'd1;
        end else if (is_q) begin
          tsl_next  = line;
          esc_next  = 1'b0;
          mode_next = ntl_pkg::MODE_QUOTE;
        end else begin
          tsl_next = line;
          res_next[k] = '{ntl_pkg::EV_BYTE, s1_byte, ntl_pkg::TYPE_WORD, start_new, 1'b0};
          k = k + 2'd1;
          mode_next = ntl_pkg::MODE_WORD;
        end
      end
    end
    for (int i = 0; i < ntl_pkg::RUN_MAX; i++) begin
      res_next[i].last_of_run = (2'(i) == k - 2'd1);
    end
    cnt_next = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_kind <= text.kind;
      s1_byte <= text.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ntl_pkg::MODE_IDLE;
      esc  <= 1'b0;
      line <= LINE_BITS'(1);
      tsl  <= LINE_BITS'(1);
    end else if (adv) begin
      mode <= mode_next;
      esc  <= esc_next;
      line <= line_next;
      tsl  <= tsl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (adv) begin
      cnt <= cnt_next;
      idx <= 2'd0;
    end else if (take_last) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < ntl_pkg::RUN_MAX; i++) begin
        res[i] <= res_next[i];
      end
    end
  end

endmodule

// ===== design/ntl_checker.sv =====
module ntl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     event_res,
  input logic [7:0]                     content,
  input logic [1:0]                     token_type,
  input logic [ntl_pkg::START_BITS-1:0] start_line,
  input logic                           last_of_run
);

  // a stalled beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(content) &&
      $stable(token_type) && $stable(start_line) && $stable(last_of_run))
    else $error("stalled result beat changed");

  // the quote error is always alone in its run and typed as quoted
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == ntl_pkg::EV_ERROR |->
      last_of_run && token_type == ntl_pkg::TYPE_QUOTE && content == 8'd0)
    else $error("bad unterminated-quote beat");

  // token ends carry no content, line numbers start at one
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != ntl_pkg::EV_BYTE |-> content == 8'd0 && start_line != '0)
    else $error("token end with content or zero line");

  // punctuation content is closed by its own end beat
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == ntl_pkg::EV_BYTE && token_type == ntl_pkg::TYPE_PUNCT |->
      !last_of_run)
    else $error("punctuation byte flagged last");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind netlist_text_lexer_core ntl_checker u_ntl_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (tokens.valid),
  .out_ready   (tokens.ready),
  .event_res   (tokens.event_res),
  .content     (tokens.content),
  .token_type  (tokens.token_type),
  .start_line  (tokens.start_line),
  .last_of_run (tokens.last_of_run)
);

// ===== test/netlist_text_lexer_core_tb.sv =====
`timescale 1ns / 100ps

localparam bit KIND_BYTE = 1'b0;
localparam bit KIND_END  = 1'b1;

function automatic bit is_separator(logic [7:0] c);
  return c == ntl_pkg::CH_SPACE || c == ntl_pkg::CH_TAB || c == ntl_pkg::CH_CR ||
         c == ntl_pkg::CH_LF || c == ntl_pkg::CH_FF;
endfunction

function automatic bit is_punct(logic [7:0] c);
  return c == ntl_pkg::CH_LPAREN || c == ntl_pkg::CH_RPAREN || c == ntl_pkg::CH_SEMI;
endfunction

class token_scoreboard #(int LB = 16);
  ntl_pkg::lex_mode_t mode;
  bit                 esc_pending;
  logic [LB-1:0]      line_cnt;
  logic [LB-1:0]      tok_line;
  ntl_pkg::res_t      run_q[$];
  ntl_pkg::res_t      expected_tokens[$];
  int                 errors;

  function new();
    mode = ntl_pkg::MODE_IDLE;
    esc_pending = 1'b0;
    line_cnt = 1;
    tok_line = 1;
    errors = 0;
  endfunction

  function void add(ntl_pkg::ev_t ev, logic [7:0] c, ntl_pkg::tok_t ty);
    ntl_pkg::res_t r;
    logic [63:0] wide;
    wide = 64'(tok_line);
    r.event_res = ev;
    r.content = c;
    r.token_type = ty;
    r.start_line = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    r.last_of_run = 1'b0;
    run_q.insert(run_q.size(), r);
  endfunction

  function void bump_line();
    if (line_cnt != '1) line_cnt++;
  endfunction

  function void between_tokens(logic [7:0] c);
    if (c == ntl_pkg::CH_HASH) begin
      mode = ntl_pkg::MODE_COMMENT;
    end else if (is_separator(c)) begin
      if (c == ntl_pkg::CH_LF) bump_line();
    end else if (is_punct(c)) begin
      tok_line = line_cnt;
      add(ntl_pkg::EV_BYTE, c, ntl_pkg::TYPE_PUNCT);
      add(ntl_pkg::EV_END, 8'h00, ntl_pkg::TYPE_PUNCT);
    end else if (c == ntl_pkg::CH_QUOTE) begin
      tok_line = line_cnt;
      esc_pending = 1'b0;
      mode = ntl_pkg::MODE_QUOTE;
    end else begin
      tok_line = line_cnt;
      add(ntl_pkg::EV_BYTE, c, ntl_pkg::TYPE_WORD);
      mode = ntl_pkg::MODE_WORD;
    end
  endfunction

  // predicts the token beats caused by one accepted input beat
  function void note_beat(bit kind, logic [7:0] c);
    run_q.delete();
    if (kind == KIND_END) begin
      if (mode == ntl_pkg::MODE_WORD) add(ntl_pkg::EV_END, 8'h00, ntl_pkg::TYPE_WORD);
      else if (mode == ntl_pkg::MODE_QUOTE)
        add(ntl_pkg::EV_ERROR, 8'h00, ntl_pkg::TYPE_QUOTE);
      mode = ntl_pkg::MODE_IDLE;
      esc_pending = 1'b0;
    end else begin
      case (mode)
        ntl_pkg::MODE_IDLE: between_tokens(c);
        ntl_pkg::MODE_COMMENT: begin
          if (c == ntl_pkg::CH_LF) begin
            bump_line();
            mode = ntl_pkg::MODE_IDLE;
          end
        end
        ntl_pkg::MODE_WORD: begin
          if (is_separator(c) || is_punct(c) || c == ntl_pkg::CH_HASH) begin
            add(ntl_pkg::EV_END, 8'h00, ntl_pkg::TYPE_WORD);
            mode = ntl_pkg::MODE_IDLE;
            between_tokens(c);
          end else begin
            add(ntl_pkg::EV_BYTE, c, ntl_pkg::TYPE_WORD);
          end
        end
        default: begin
          if (c == ntl_pkg::CH_LF) bump_line();
          if (c == ntl_pkg::CH_QUOTE && !esc_pending) begin
            add(ntl_pkg::EV_END, 8'h00, ntl_pkg::TYPE_QUOTE);
            mode = ntl_pkg::MODE_IDLE;
            esc_pending = 1'b0;
          end else begin
            add(ntl_pkg::EV_BYTE, c, ntl_pkg::TYPE_QUOTE);
            esc_pending = (c == ntl_pkg::CH_BSLASH && !esc_pending);
          end
        end
      endcase
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
    foreach (run_q[i]) expected_tokens.insert(expected_tokens.size(), run_q[i]);
  endfunction

  function void check_beat(ntl_pkg::res_t got);
    ntl_pkg::res_t want;
    if (expected_tokens.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected token beat: ev=%0d byte=%02h type=%0d line=%0d last=%0b",
                 got.event_res, got.content, got.token_type, got.start_line,
                 got.last_of_run);
      return;
    end
    want = expected_tokens.pop_front();
    if (got.event_res !== want.event_res || got.content !== want.content ||
        got.token_type !== want.token_type || got.start_line !== want.start_line ||
        got.last_of_run !== want.last_of_run) begin
      errors++;
      if (errors <= 10)
        $display("token beat mismatch: expected ev=%0d byte=%02h type=%0d line=%0d last=%0b, %s",
                 want.event_res, want.content, want.token_type, want.start_line,
                 want.last_of_run,
                 $sformatf("got ev=%0d byte=%02h type=%0d line=%0d last=%0b",
                           got.event_res, got.content, got.token_type,
                           got.start_line, got.last_of_run));
    end
  endfunction
endclass

module netlist_text_lexer_core_tb;

  // narrowest line counter, start_line is zero-extended
  localparam int LINE_W      = 16;
  localparam int CYCLE_LIMIT = 50_000;
  localparam int RANDOM_ITEMS = 340;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idle_en = 1'b1;
  int   stall_left = 0;
  int   cycles = 0;
  int   sent_random = 0;

  token_scoreboard #(LINE_W) sb;

  ntl_in_if  text_if();
  ntl_out_if tok_if();

  netlist_text_lexer_core #(.LINE_BITS(LINE_W)) dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if),
    .tokens (tok_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // token side: check each beat, stall in short random bursts
  always @(posedge clk) begin : drain_tokens
    ntl_pkg::res_t got;
    if (rst) begin
      tok_if.ready <= 1'b0;
    end else begin
      if (tok_if.valid && tok_if.ready) begin
        got.event_res = ntl_pkg::ev_t'(tok_if.event_res);
        got.content = tok_if.content;
        got.token_type = ntl_pkg::tok_t'(tok_if.token_type);
        got.start_line = tok_if.start_line;
        got.last_of_run = tok_if.last_of_run;
        sb.check_beat(got);
      end
      if (stall_left > 0) stall_left--;
      else if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
      tok_if.ready <= (stall_left == 0);
    end
  end

  task automatic send_beat(bit kind, logic [7:0] b);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    text_if.valid <= 1'b1;
    text_if.kind <= kind;
    // the byte lane is don't-care on an end mark, so keep it moving
    text_if.text_byte <= (kind == KIND_END) ? 8'($urandom) : b;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    sb.note_beat(kind, b);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_beat(KIND_BYTE, b);
    sent_random++;
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    do c = 8'($urandom);
    while (is_separator(c) || is_punct(c) || c == ntl_pkg::CH_HASH ||
           c == ntl_pkg::CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] separator_byte();
    case ($urandom_range(0, 4))
      0: return ntl_pkg::CH_SPACE;
      1: return ntl_pkg::CH_TAB;
      2: return ntl_pkg::CH_CR;
      3: return ntl_pkg::CH_LF;
      default: return ntl_pkg::CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] punct_byte();
    case ($urandom_range(0, 2))
      0: return ntl_pkg::CH_LPAREN;
      1: return ntl_pkg::CH_RPAREN;
      default: return ntl_pkg::CH_SEMI;
    endcase
  endfunction

  task automatic run_directed();
    logic [8:0] seq[] = '{
      {KIND_BYTE, 8'h00}, {KIND_BYTE, 8'hff}, {KIND_BYTE, ntl_pkg::CH_LPAREN},
      {KIND_BYTE, ntl_pkg::CH_RPAREN}, {KIND_BYTE, ntl_pkg::CH_SEMI},
      {KIND_BYTE, ntl_pkg::CH_QUOTE}, {KIND_BYTE, ntl_pkg::CH_QUOTE},
      {KIND_BYTE, ntl_pkg::CH_QUOTE}, {KIND_BYTE, ntl_pkg::CH_BSLASH},
      {KIND_BYTE, ntl_pkg::CH_QUOTE},
      {KIND_BYTE, ntl_pkg::CH_BSLASH}, {KIND_BYTE, ntl_pkg::CH_BSLASH},
      {KIND_BYTE, ntl_pkg::CH_LF},
      {KIND_BYTE, ntl_pkg::CH_QUOTE},
      {KIND_BYTE, 8'h61}, {KIND_BYTE, ntl_pkg::CH_QUOTE}, {KIND_BYTE, ntl_pkg::CH_TAB},
      {KIND_BYTE, 8'h62}, {KIND_BYTE, ntl_pkg::CH_CR}, {KIND_BYTE, 8'h63},
      {KIND_BYTE, ntl_pkg::CH_FF},
      {KIND_BYTE, 8'h64}, {KIND_BYTE, ntl_pkg::CH_HASH}, {KIND_BYTE, 8'h7a},
      {KIND_BYTE, ntl_pkg::CH_LF},
      {KIND_BYTE, 8'h65}, {KIND_END, 8'h00},
      {KIND_BYTE, ntl_pkg::CH_QUOTE}, {KIND_END, 8'h00},
      {KIND_BYTE, ntl_pkg::CH_HASH}, {KIND_END, 8'h00}, {KIND_END, 8'h00}
    };
    foreach (seq[i]) send_beat(seq[i][8], seq[i][7:0]);
  endtask

  // mostly well-formed tokens with random content, plus some noise
  task automatic run_random();
    int n;
    while (sent_random < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) idle_en = !idle_en;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(1, 6);
          repeat (n) send_byte(word_byte());
          case ($urandom_range(0, 3))
            0: send_byte(punct_byte());
            1: send_byte(ntl_pkg::CH_HASH);
            default: send_byte(separator_byte());
          endcase
        end
        3: send_byte(punct_byte());
        4, 5: begin
          send_byte(ntl_pkg::CH_QUOTE);
          n = $urandom_range(0, 6);
          repeat (n) begin
            case ($urandom_range(0, 9))
              0, 1: send_byte(ntl_pkg::CH_BSLASH);
              2: send_byte(ntl_pkg::CH_LF);
              3: send_byte(ntl_pkg::CH_QUOTE);
              default: send_byte(8'($urandom));
            endcase
          end
          if ($urandom_range(0, 7) == 0) send_beat(KIND_END, 8'h00);
          else send_byte(ntl_pkg::CH_QUOTE);
        end
        6: begin
          send_byte(ntl_pkg::CH_HASH);
          n = $urandom_range(0, 5);
          repeat (n) send_byte(8'($urandom));
          send_byte(ntl_pkg::CH_LF);
        end
        7: send_byte(separator_byte());
        8: send_beat(KIND_END, 8'h00);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  // closing stretch of back-to-back beats: line feeds, words, a quote, a comment and a punctuation mark
  task automatic run_tail();
    for (int i = 0; i < 20; i++)
      send_beat(KIND_BYTE, (i % 5 == 0) ? 8'h6b : ntl_pkg::CH_LF);
    send_beat(KIND_BYTE, ntl_pkg::CH_QUOTE);
    send_beat(KIND_BYTE, ntl_pkg::CH_LF);
    send_beat(KIND_BYTE, 8'h79);
    send_beat(KIND_BYTE, ntl_pkg::CH_QUOTE);
    send_beat(KIND_BYTE, ntl_pkg::CH_HASH);
    send_beat(KIND_BYTE, ntl_pkg::CH_LF);
    send_beat(KIND_BYTE, 8'h78);
    send_beat(KIND_BYTE, ntl_pkg::CH_LPAREN);
    send_beat(KIND_BYTE, 8'h77);
    send_beat(KIND_END, 8'h00);
  endtask

  initial begin
    sb = new();
    text_if.valid = 1'b0;
    text_if.kind = KIND_BYTE;
    text_if.text_byte = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random();
    idle_en = 1'b0;
    run_tail();
    text_if.valid <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
